FILE: design/websocket_frame_deframer_unit_assert.svh
// Assertion macros for the WebSocket frame deframer.
// Included by the deframer top level; needs no package.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WSFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsfd: same-cycle check failed");
`define WSFD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsfd: next-cycle check failed");
`else
`define WSFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define WSFD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/wsfd_pkg.sv
// Types and constants of the WebSocket frame deframer.
// No dependencies; used by the interfaces and the top level.
package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_MASK,
      PH_BODY
   } phase_type;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] err_type;
   typedef logic [3:0] opcode_type;

   localparam kind_type KIND_DATA  = 2'd0;
   localparam kind_type KIND_PONGB = 2'd1;
   localparam kind_type KIND_PONGR = 2'd2;
   localparam kind_type KIND_ERROR = 2'd3;

   localparam err_type ERR_TOO_LARGE = 2'd0;
   localparam err_type ERR_CLOSE     = 2'd1;
   localparam err_type ERR_OPCODE    = 2'd2;

   localparam opcode_type OP_CONT   = 4'h0;
   localparam opcode_type OP_TEXT   = 4'h1;
   localparam opcode_type OP_BINARY = 4'h2;
   localparam opcode_type OP_CLOSE  = 4'h8;
   localparam opcode_type OP_PING   = 4'h9;
   localparam opcode_type OP_PONG   = 4'hA;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // header byte counts are held as bytes still due minus one
   localparam logic [2:0] CNT_EXT16 = 3'd1;
   localparam logic [2:0] CNT_EXT64 = 3'd7;
   localparam logic [2:0] CNT_MASK  = 3'd3;

   localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;

endpackage

FILE: design/wsfd_stream_if.sv
// Valid/ready channel interfaces of the WebSocket frame deframer.
// Depends on wsfd_pkg for the result field types.
interface wsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfd_rsp_if;
   logic                 valid;
   logic                 ready;
   wsfd_pkg::kind_type   kind;
   logic [7:0]           out_byte;
   logic                 frame_last;
   wsfd_pkg::err_type    error_code;

   modport source (output valid, output kind, output out_byte, output frame_last,
                   output error_code, input ready);
   modport sink   (input valid, input kind, input out_byte, input frame_last,
                   input error_code, output ready);
endinterface

FILE: design/websocket_frame_deframer_unit.sv
// WebSocket receive deframer: takes one stream byte per transaction, parses the frame
// header, unmasks the payload and returns at most one result per byte through a
// registered output. A byte is taken every cycle, held back only while the result
// register holds a result the sink has not taken. All per-byte work, including the
// 64-bit length compare and countdown, sits between the parse state and the result
// register. Any error is sticky until reset; later bytes are consumed silently.
// Depends on wsfd_pkg, wsfd_stream_if and websocket_frame_deframer_unit_assert.svh.
`include "websocket_frame_deframer_unit_assert.svh"

module websocket_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   wsfd_req_if.sink    req_if,
   wsfd_rsp_if.source  rsp_if
);
   import wsfd_pkg::*;

   logic [31:0] max_len_ff;
   phase_type   phase_ff, phase_in;
   opcode_type  op_ff, op_in;
   logic        mask_ff, mask_in;
   logic [63:0] rem_ff, rem_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;
   logic        failed_ff, failed_in;

   logic        rsp_valid_ff;
   kind_type    rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;
   err_type     rsp_err_ff;

   logic        req_fire, work;
   logic [7:0]  in_b;
   logic [6:0]  len7;
   logic        len7_ext;
   logic [63:0] len_value, start_len;
   logic        len_known, too_large, mask_new, start_evt, start_empty;
   logic        in_body, body_last, op_data, op_fail;
   logic [7:0]  key_byte, body_byte;

   logic        res_valid, res_last;
   kind_type    res_kind;
   logic [7:0]  res_byte;
   err_type     res_err;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign work         = req_fire && !failed_ff;
   assign in_b         = req_if.in_byte;

   assign len7      = in_b[6:0];
   assign len7_ext  = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
   assign len_value = (phase_ff == PH_HDR1) ? {57'd0, len7} : {rem_ff[55:0], in_b};
   assign len_known = ((phase_ff == PH_HDR1) && !len7_ext) ||
                      ((phase_ff == PH_EXTLEN) && (cnt_ff == 3'd0));
   assign too_large = len_value > {32'd0, max_len_ff};
   assign mask_new  = (phase_ff == PH_HDR1) ? in_b[7] : mask_ff;
   assign start_evt = (len_known && !too_large && !mask_new) ||
                      ((phase_ff == PH_MASK) && (cnt_ff == 3'd0));
   assign start_len   = (phase_ff == PH_MASK) ? rem_ff : len_value;
   assign start_empty = (start_len == 64'd0);

   assign in_body   = (phase_ff == PH_BODY);
   assign body_last = (rem_ff[63:1] == 63'd0);
   assign op_data   = (op_ff == OP_CONT) || (op_ff == OP_BINARY);
   assign op_fail   = !((op_ff == OP_CONT) || (op_ff == OP_TEXT) || (op_ff == OP_BINARY) ||
                        (op_ff == OP_PING) || (op_ff == OP_PONG));
   assign key_byte  = key_ff[{~idx_ff, 3'b000} +: 8];
   assign body_byte = mask_ff ? (in_b ^ key_byte) : in_b;

   always_comb begin
      phase_in  = phase_ff;
      op_in     = op_ff;
      mask_in   = mask_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      failed_in = failed_ff;
      if (work) begin
         case (phase_ff)
            PH_HDR0: begin
               op_in    = in_b[3:0];
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = in_b[7];
               if (len7_ext) begin
                  rem_in   = 64'd0;
                  cnt_in   = (len7 == LEN_EXT16) ? CNT_EXT16 : CNT_EXT64;
                  phase_in = PH_EXTLEN;
               end else begin
                  rem_in = len_value;
               end
            end
            PH_EXTLEN: begin
               rem_in = len_value;
               cnt_in = cnt_ff - 3'd1;
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], in_b};
               cnt_in = cnt_ff - 3'd1;
            end
            PH_BODY: begin
               idx_in = idx_ff + 2'd1;
               if (rem_ff != 64'd0) begin
                  rem_in = rem_ff - 64'd1;
               end
               if (body_last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
         if (len_known && too_large) begin
            failed_in = 1'b1;
            phase_in  = PH_HDR0;
         end else if (len_known && mask_new) begin
            key_in   = 32'd0;
            cnt_in   = CNT_MASK;
            phase_in = PH_MASK;
         end else if (start_evt) begin
            idx_in   = 2'd0;
            phase_in = start_empty ? PH_HDR0 : PH_BODY;
         end
         if ((start_evt && start_empty && (op_ff != OP_PING) && op_fail) ||
             (in_body && body_last && op_fail)) begin
            failed_in = 1'b1;
         end
      end
   end

   always_comb begin
      res_valid = 1'b0;
      res_kind  = KIND_DATA;
      res_byte  = 8'd0;
      res_last  = 1'b0;
      res_err   = ERR_TOO_LARGE;
      if (work) begin
         if (len_known && too_large) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_err   = ERR_TOO_LARGE;
         end else if (start_evt && start_empty) begin
            if (op_ff == OP_PING) begin
               res_valid = 1'b1;
               res_kind  = KIND_PONGR;
               res_last  = 1'b1;
            end else if (op_fail) begin
               res_valid = 1'b1;
               res_kind  = KIND_ERROR;
               res_err   = (op_ff == OP_CLOSE) ? ERR_CLOSE : ERR_OPCODE;
            end
         end else if (in_body) begin
            if (op_data || (op_ff == OP_PING)) begin
               res_valid = 1'b1;
               res_kind  = op_data ? KIND_DATA : KIND_PONGB;
               res_byte  = body_byte;
               res_last  = body_last;
            end else if (body_last && op_fail) begin
               res_valid = 1'b1;
               res_kind  = KIND_ERROR;
               res_err   = (op_ff == OP_CLOSE) ? ERR_CLOSE : ERR_OPCODE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         phase_ff     <= PH_HDR0;
         op_ff        <= OP_CONT;
         mask_ff      <= 1'b0;
         rem_ff       <= 64'd0;
         cnt_ff       <= 3'd0;
         key_ff       <= 32'd0;
         idx_ff       <= 2'd0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         mask_ff   <= mask_in;
         rem_ff    <= rem_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         failed_ff <= failed_in;
         if (res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_byte_ff <= res_byte;
         rsp_last_ff <= res_last;
         rsp_err_ff  <= res_err;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = rsp_kind_ff;
   assign rsp_if.out_byte   = rsp_byte_ff;
   assign rsp_if.frame_last = rsp_last_ff;
   assign rsp_if.error_code = rsp_err_ff;

   `WSFD_ASSERT_IMP(a_silent_after_error, clock, reset, failed_ff, !res_valid)
   `WSFD_ASSERT_NXT(a_error_sticks, clock, reset, res_valid && (res_kind == KIND_ERROR), failed_ff)
   `WSFD_ASSERT_IMP(a_body_has_length, clock, reset, phase_ff == PH_BODY, rem_ff != 64'd0)
   `WSFD_ASSERT_NXT(a_last_ends_frame, clock, reset, work && in_body && body_last,
                    phase_ff == PH_HDR0)

endmodule
